[rtl/core/apnsc_pkg.sv]
// Package for the archive path name safety check.
// Holds the character constants, the classified-byte type and the queue depth.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package apnsc_pkg;

   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam int QUEUE_DEPTH = 2;

   // One name byte after classification by the front end.
   typedef struct packed {
      logic [7:0] folded;     // byte with A-Z folded to lower case
      logic       sep;        // '/' or '\'
      logic       dot;
      logic       space_dot;  // ' ' or '.'
      logic       nul;
      logic       colon;
      logic       letter;     // ASCII letter, either case
      logic       last;
   } class_type;

endpackage

[rtl/core/apnsc_front.sv]
// Front end of the path name check: accepts name bytes and classifies them.
// Pushes one class_type item per accepted byte into the queue.
// Depends on apnsc_pkg.
`timescale 1ns / 1ps

module apnsc_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] name_byte
   input  logic                req_tlast,   // last_byte
   input  logic                q_full,
   output logic                q_push,
   output apnsc_pkg::class_type q_item
);
   import apnsc_pkg::*;

   logic [7:0] c;

   assign c          = req_tdata;
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item = '0;
      q_item.folded    = (c inside {[CH_UA:CH_UZ]}) ? c + CASE_OFFSET : c;
      q_item.sep       = (c == CH_SLASH) || (c == CH_BSLASH);
      q_item.dot       = (c == CH_DOT);
      q_item.space_dot = (c == CH_DOT) || (c == CH_SPACE);
      q_item.nul       = (c == CH_NUL);
      q_item.colon     = (c == CH_COLON);
      q_item.letter    = (c inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]});
      q_item.last      = req_tlast;
   end

endmodule

[rtl/core/apnsc_queue.sv]
// Short queue of classified bytes between front and back end.
// Register array with head and tail pointers; head entry is read directly.
// Depends on apnsc_pkg.
`timescale 1ns / 1ps

module apnsc_queue #(
   parameter int DEPTH = apnsc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  apnsc_pkg::class_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output apnsc_pkg::class_type head_item
);
   import apnsc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   class_type       entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/apnsc_back.sv]
// Back end of the path name check: segment trackers, sticky reject and the
// verdict register that drives the result channel.
// Depends on apnsc_pkg.
`timescale 1ns / 1ps

module apnsc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  apnsc_pkg::class_type head_item,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata    // [0] safe, [7:1] zero
);
   import apnsc_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic       first_letter_ff, first_letter_in;
   logic       rejected_ff, rejected_in;
   logic [1:0] seg_len_ff, seg_len_in;
   logic       first_dot_ff, first_dot_in;
   logic       second_dot_ff, second_dot_in;
   logic       prev_sd_ff, prev_sd_in;
   logic [2:0] base_len_ff, base_len_in;
   logic       base_ended_ff, base_ended_in;
   logic [7:0] letters_ff [4];
   logic [7:0] letters_in [4];
   logic       rsp_valid_ff, rsp_valid_in;
   logic       safe_ff, safe_in;
   logic       out_free;

   function automatic logic seg_bad(
      input logic [1:0] len,
      input logic       fd,
      input logic       sd,
      input logic       psd,
      input logic [2:0] blen,
      input logic [7:0] l0,
      input logic [7:0] l1,
      input logic [7:0] l2,
      input logic [7:0] l3
   );
      logic [23:0] head3;
      logic        rsv;
      head3 = {l0, l1, l2};
      rsv   = 1'b0;
      if (blen == 3'd3) begin
         rsv = (head3 == "con") || (head3 == "prn") || (head3 == "aux") ||
               (head3 == "nul");
      end else if (blen == 3'd4) begin
         rsv = ((head3 == "com") || (head3 == "lpt")) && (l3 >= CH_ONE) &&
               (l3 <= CH_NINE);
      end
      return ((len == 2'd1) && fd) || ((len == 2'd2) && fd && sd) || psd || rsv;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = head_valid && (!head_item.last || out_free);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, safe_ff};

   always_comb begin
      pos_in          = pos_ff;
      first_letter_in = first_letter_ff;
      rejected_in     = rejected_ff;
      seg_len_in      = seg_len_ff;
      first_dot_in    = first_dot_ff;
      second_dot_in   = second_dot_ff;
      prev_sd_in      = prev_sd_ff;
      base_len_in     = base_len_ff;
      base_ended_in   = base_ended_ff;
      letters_in      = letters_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      safe_in         = safe_ff;

      if (pop) begin
         // Drive letter and leading separator checks on the first two bytes
         case (pos_ff)
            2'd0: begin
               if (head_item.sep) begin
                  rejected_in = 1'b1;
               end
               first_letter_in = head_item.letter;
            end
            2'd1: begin
               if (first_letter_ff && head_item.colon) begin
                  rejected_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (pos_ff != 2'd2) begin
            pos_in = pos_ff + 2'd1;
         end
         if (head_item.nul) begin
            rejected_in = 1'b1;
         end

         if (head_item.sep) begin
            if ((seg_len_ff == 2'd0) ||
                seg_bad(seg_len_ff, first_dot_ff, second_dot_ff, prev_sd_ff,
                        base_len_ff, letters_ff[0], letters_ff[1], letters_ff[2],
                        letters_ff[3])) begin
               rejected_in = 1'b1;
            end
            seg_len_in    = '0;
            first_dot_in  = 1'b0;
            second_dot_in = 1'b0;
            prev_sd_in    = 1'b0;
            base_len_in   = '0;
            base_ended_in = 1'b0;
            letters_in    = '{default: '0};
         end else begin
            if (seg_len_ff == 2'd0) begin
               first_dot_in = head_item.dot;
            end else if (seg_len_ff == 2'd1) begin
               second_dot_in = head_item.dot;
            end
            if (seg_len_ff != 2'd3) begin
               seg_len_in = seg_len_ff + 2'd1;
            end
            prev_sd_in = head_item.space_dot;
            if (!base_ended_ff) begin
               if (head_item.dot) begin
                  base_ended_in = 1'b1;
               end else begin
                  if (base_len_ff < 3'd4) begin
                     letters_in[base_len_ff[1:0]] = head_item.folded;
                  end
                  if (base_len_ff < 3'd5) begin
                     base_len_in = base_len_ff + 3'd1;
                  end
               end
            end
            // Check the final segment on the tracker values just updated
            if (head_item.last &&
                seg_bad(seg_len_in, first_dot_in, second_dot_in, prev_sd_in,
                        base_len_in, letters_in[0], letters_in[1], letters_in[2],
                        letters_in[3])) begin
               rejected_in = 1'b1;
            end
         end

         if (head_item.last) begin
            rsp_valid_in    = 1'b1;
            safe_in         = !rejected_in;
            pos_in          = '0;
            first_letter_in = 1'b0;
            rejected_in     = 1'b0;
            seg_len_in      = '0;
            first_dot_in    = 1'b0;
            second_dot_in   = 1'b0;
            prev_sd_in      = 1'b0;
            base_len_in     = '0;
            base_ended_in   = 1'b0;
            letters_in      = '{default: '0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         first_letter_ff <= 1'b0;
         rejected_ff     <= 1'b0;
         seg_len_ff      <= '0;
         first_dot_ff    <= 1'b0;
         second_dot_ff   <= 1'b0;
         prev_sd_ff      <= 1'b0;
         base_len_ff     <= '0;
         base_ended_ff   <= 1'b0;
         letters_ff      <= '{default: '0};
         rsp_valid_ff    <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         first_letter_ff <= first_letter_in;
         rejected_ff     <= rejected_in;
         seg_len_ff      <= seg_len_in;
         first_dot_ff    <= first_dot_in;
         second_dot_ff   <= second_dot_in;
         prev_sd_ff      <= prev_sd_in;
         base_len_ff     <= base_len_in;
         base_ended_ff   <= base_ended_in;
         letters_ff      <= letters_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      safe_ff <= safe_in;
   end

endmodule

[rtl/core/archive_path_name_safety_check.sv]
// Archive path name safety check: checks an entry path name, one byte per
// item, and returns a single safe/unsafe verdict after the last byte.
// The req channel carries name bytes, req_tlast on the final byte of a name.
// The rsp channel carries one item per name: rsp_tdata[0] is 1 for a safe
// name, 0 for a rejected one. Bytes without req_tlast give no rsp item.
// Throughput is one byte per cycle while the queue has room: the front end
// classifies a byte as it is accepted, the back end updates its segment
// trackers. With an empty queue, the last byte enters the queue at the
// accepting edge and the back end then loads the verdict register from the
// queue head.
// A queue of QUEUE_DEPTH classified bytes sits between front and back end.
// When rsp_tready is low, the verdict holds, bytes that do not end a name
// still drain, and req_tready drops once the queue fills behind a last byte.
// Reset (synchronous, active high) empties the queue, drops rsp_tvalid and
// starts a new name with the next byte.
// Depends on apnsc_pkg, apnsc_front, apnsc_queue and apnsc_back.
`timescale 1ns / 1ps

module archive_path_name_safety_check #(
   parameter int QUEUE_DEPTH = apnsc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] name_byte
   input  logic       req_tlast,    // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [0] safe, [7:1] zero
);
   import apnsc_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_head_valid;
   class_type q_push_item;
   class_type q_head_item;

   apnsc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   apnsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   apnsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
